// ===== rtl/lph_pkg.sv =====
package lph_pkg;

  localparam int unsigned KeyW     = 32;
  localparam int unsigned ValW     = 32;
  localparam int unsigned SizeW    = 9;
  localparam int unsigned SlotOutW = 8;
  localparam int unsigned SlotMaxW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned DivBits  = 4;
  localparam int unsigned DivSteps = KeyW / DivBits;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpUpdate = 2'd1,
    OpDelete = 2'd2,
    OpQuery  = 2'd3
  } lph_op_e;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StDup  = 2'd1,
    StFull = 2'd2,
    StMiss = 2'd3
  } lph_status_e;

  typedef enum logic [1:0] {
    MarkEmpty = 2'd0,
    MarkUsed  = 2'd1,
    MarkTomb  = 2'd2,
    MarkBad   = 2'd3
  } lph_mark_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTableSize = 2'd0,
    CfgDupPolicy = 2'd1,
    CfgUnused2   = 2'd2,
    CfgUnused3   = 2'd3
  } lph_cfg_e;

  typedef struct packed {
    lph_op_e         operation;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } lph_req_t;

  typedef struct packed {
    lph_status_e         status;
    logic [31:0]         read_value;
    logic [SlotOutW-1:0] slot_index;
  } lph_rsp_t;

  typedef struct packed {
    lph_req_t            req;
    logic [SlotMaxW-1:0] home;
  } lph_job_t;

endpackage

// ===== rtl/linear_probe_hash_table.sv =====
// key-value table, open addressing with linear probing
// request side: drive req_i and raise push while full is low; one beat per
// edge with push high and full low. ops: insert, update, delete, query
// result side: one result beat per request, in request order; it sits on
// rsp_o while empty is low and leaves on an edge with pop high
// cfg port: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 table size,
// 1 dup policy); user writes only while the block is idle, not enforced
// steps from accept to result on rsp_o: the front part takes the home-slot
// remainder (4 key bits a cycle) and hands the job to the job queue; the back
// part takes it and, per probed slot, does a registered slot memory read, then
// compare and write; it then pushes the result into the result queue
// front and back overlap through a 2-beat job queue, so the front can take a
// new request while the back part still probes the last one
// reset: slot marks are swept to empty while full stays high
// stall: full is high while the front part works on a request; a 2-beat
// result queue holds results, and when it and the job queue fill, requests wait
module linear_probe_hash_table #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  lph_pkg::lph_req_t            req_i,
  output logic                         empty,
  input  logic                         pop,
  output lph_pkg::lph_rsp_t            rsp_o,
  input  logic                         cfg_we_i,
  input  logic [lph_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lph_pkg::SizeW-1:0]    cfg_data_i
);

  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);

  logic [lph_pkg::SizeW-1:0] table_size_q;
  logic                      dup_policy_q;
  logic [NW-1:0]             size_eff;
  logic                      clearing;
  logic                      job_push, job_full, job_pop, job_empty;
  lph_pkg::lph_job_t         job_in, job_out;
  logic                      rsp_push, rsp_full;
  lph_pkg::lph_rsp_t         rsp_back;
  lph_pkg::lph_cfg_e         cfg_sel;

  assign cfg_sel = lph_pkg::lph_cfg_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= lph_pkg::SizeW'(256);
      dup_policy_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_sel)
        lph_pkg::CfgTableSize: table_size_q <= cfg_data_i;
        lph_pkg::CfgDupPolicy: dup_policy_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (table_size_q == '0) size_eff = NW'(1);
    else if (32'(table_size_q) > TABLE_DEPTH) size_eff = NW'(TABLE_DEPTH);
    else size_eff = NW'(table_size_q);
  end

  lph_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .size_i     (size_eff),
    .hold_i     (clearing),
    .push_i     (push),
    .req_i      (req_i),
    .full_o     (full),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  lph_fifo #(.WIDTH($bits(lph_pkg::lph_job_t))) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  lph_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .size_i       (size_eff),
    .dup_policy_i (dup_policy_q),
    .job_i        (job_out),
    .job_empty_i  (job_empty),
    .job_pop_o    (job_pop),
    .rsp_o        (rsp_back),
    .rsp_push_o   (rsp_push),
    .rsp_full_i   (rsp_full),
    .clearing_o   (clearing)
  );

  lph_fifo #(.WIDTH($bits(lph_pkg::lph_rsp_t))) u_rsp_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .data_i  (rsp_back),
    .full_o  (rsp_full),
    .pop_i   (pop),
    .data_o  (rsp_o),
    .empty_o (empty)
  );

endmodule

// ===== rtl/lph_fifo.sv =====
module lph_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ===== rtl/lph_front.sv =====
module lph_front #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] size_i,
  input  logic               hold_i,
  input  logic               push_i,
  input  lph_pkg::lph_req_t  req_i,
  output logic               full_o,
  output logic               job_push_o,
  output lph_pkg::lph_job_t  job_o,
  input  logic               job_full_i
);

  localparam int unsigned SW = $clog2(TABLE_DEPTH);

  typedef enum logic [2:0] {
    FrIdle = 3'b001,
    FrDiv  = 3'b010,
    FrSend = 3'b100
  } fr_state_e;

  fr_state_e                     state_q, state_d;
  lph_pkg::lph_req_t             req_q;
  logic [lph_pkg::KeyW-1:0]      shr_q, shr_d;
  logic [SW-1:0]                 rem_q, rem_d;
  logic [lph_pkg::DivCntW-1:0]   step_q;
  logic [SW:0]                   t;

  assign full_o = (state_q != FrIdle) || hold_i;

  // radix-16 remainder step, msb first
  always_comb begin
    rem_d = rem_q;
    shr_d = shr_q;
    t     = '0;
    for (int i = 0; i < int'(lph_pkg::DivBits); i++) begin
      t = {rem_d, shr_d[lph_pkg::KeyW-1]};
      if (t >= (SW+1)'(size_i)) t = t - (SW+1)'(size_i);
      rem_d = t[SW-1:0];
      shr_d = {shr_d[lph_pkg::KeyW-2:0], 1'b0};
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FrIdle: if (push_i && !full_o) state_d = FrDiv;
      FrDiv:  if (step_q == lph_pkg::DivCntW'(lph_pkg::DivSteps - 1)) state_d = FrSend;
      FrSend: if (!job_full_i) state_d = FrIdle;
      default: state_d = FrIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == FrDiv) step_q <= step_q + 1'b1;
      else step_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FrIdle) begin
      req_q <= req_i;
      shr_q <= req_i.key;
      rem_q <= '0;
    end else if (state_q == FrDiv) begin
      shr_q <= shr_d;
      rem_q <= rem_d;
    end
  end

  assign job_push_o = (state_q == FrSend);
  assign job_o.req  = req_q;
  assign job_o.home = lph_pkg::SlotMaxW'(rem_q);

endmodule

// ===== rtl/lph_back.sv =====
module lph_back #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] size_i,
  input  logic               dup_policy_i,
  input  lph_pkg::lph_job_t  job_i,
  input  logic               job_empty_i,
  output logic               job_pop_o,
  output lph_pkg::lph_rsp_t  rsp_o,
  output logic               rsp_push_o,
  input  logic               rsp_full_i,
  output logic               clearing_o
);

  localparam int unsigned SW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KW = lph_pkg::KeyW;
  localparam int unsigned VW = lph_pkg::ValW;

  typedef enum logic [4:0] {
    BkClear = 5'b00001,
    BkIdle  = 5'b00010,
    BkRead  = 5'b00100,
    BkCheck = 5'b01000,
    BkDone  = 5'b10000
  } bk_state_e;

  bk_state_e             state_q, state_d;
  lph_pkg::lph_op_e      op_q;
  logic [KW-1:0]         key_q;
  logic [VW-1:0]         val_q;
  logic [SW-1:0]         s_q, s_d;
  logic [NW-1:0]         cnt_q, cnt_d;
  logic [SW:0]           clr_q;
  lph_pkg::lph_rsp_t     rsp_q, rsp_d;

  lph_pkg::lph_mark_e    mark_mem [TABLE_DEPTH];
  logic [KW+VW-1:0]      kv_mem [TABLE_DEPTH];
  lph_pkg::lph_mark_e    mark_rq;
  logic [KW+VW-1:0]      kv_rq;

  logic                  mark_we, kv_we;
  logic [SW-1:0]         mark_wa;
  lph_pkg::lph_mark_e    mark_wd;

  logic                  is_write, overwrite, used, match, last;
  logic [NW-1:0]         cnt_inc, s_inc;

  assign clearing_o = (state_q == BkClear);
  assign job_pop_o  = (state_q == BkIdle) && !job_empty_i;
  assign rsp_push_o = (state_q == BkDone);
  assign rsp_o      = rsp_q;

  assign is_write  = (op_q == lph_pkg::OpInsert) || (op_q == lph_pkg::OpUpdate);
  assign overwrite = (op_q == lph_pkg::OpUpdate) || dup_policy_i;
  assign used      = (mark_rq == lph_pkg::MarkUsed);
  assign match     = used && (kv_rq[KW+VW-1:VW] == key_q);
  assign cnt_inc   = cnt_q + 1'b1;
  assign s_inc     = NW'(s_q) + 1'b1;
  assign last      = (cnt_inc == size_i);

  always_comb begin
    state_d = state_q;
    s_d     = s_q;
    cnt_d   = cnt_q;
    rsp_d   = rsp_q;
    mark_we = 1'b0;
    mark_wa = s_q;
    mark_wd = lph_pkg::MarkEmpty;
    kv_we   = 1'b0;
    unique case (state_q)
      BkClear: begin
        mark_we = 1'b1;
        mark_wa = clr_q[SW-1:0];
        if (clr_q == (SW+1)'(TABLE_DEPTH - 1)) state_d = BkIdle;
      end
      BkIdle: begin
        if (!job_empty_i) begin
          s_d     = job_i.home[SW-1:0];
          cnt_d   = '0;
          state_d = BkRead;
        end
      end
      BkRead: state_d = BkCheck;
      BkCheck: begin
        rsp_d.status     = lph_pkg::StOk;
        rsp_d.read_value = '0;
        rsp_d.slot_index = lph_pkg::SlotOutW'(s_q);
        state_d          = BkDone;
        if (is_write && match) begin
          if (overwrite) kv_we = 1'b1;
          else rsp_d.status = lph_pkg::StDup;
        end else if (is_write && !used) begin
          mark_we = 1'b1;
          mark_wd = lph_pkg::MarkUsed;
          kv_we   = 1'b1;
        end else if (!is_write && match) begin
          if (op_q == lph_pkg::OpDelete) begin
            mark_we = 1'b1;
            mark_wd = lph_pkg::MarkTomb;
          end else begin
            rsp_d.read_value = 32'(kv_rq[VW-1:0]);
          end
        end else if ((!is_write && mark_rq == lph_pkg::MarkEmpty) || last) begin
          rsp_d.status     = is_write ? lph_pkg::StFull : lph_pkg::StMiss;
          rsp_d.slot_index = '0;
        end else begin
          cnt_d   = cnt_inc;
          s_d     = (s_inc == size_i) ? '0 : s_inc[SW-1:0];
          state_d = BkRead;
        end
      end
      BkDone: if (!rsp_full_i) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkClear;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BkClear) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    cnt_q <= cnt_d;
    rsp_q <= rsp_d;
    if (job_pop_o) begin
      op_q  <= job_i.req.operation;
      key_q <= job_i.req.key;
      val_q <= job_i.req.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_rq <= mark_mem[s_q];
  end

  always_ff @(posedge clk_i) begin
    if (kv_we) kv_mem[s_q] <= {key_q, val_q};
    kv_rq <= kv_mem[s_q];
  end

  a_fail_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_push_o && (rsp_q.status == lph_pkg::StFull || rsp_q.status == lph_pkg::StMiss)
    |-> rsp_q.slot_index == '0) else $error("failed beat carries a slot");

  a_value_only_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_push_o && (op_q != lph_pkg::OpQuery || rsp_q.status != lph_pkg::StOk)
    |-> rsp_q.read_value == '0) else $error("read value on non-query beat");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BkCheck |-> cnt_q < size_i) else $error("probe count past table size");

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_o |-> !job_pop_o) else $error("job taken while clearing");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BkRead |=> NW'(s_q) < size_i) else $error("slot beyond table size");

endmodule
